FILE: hw/rtl/rope_pkg.sv
// Shared types, constants and build-time helpers for the rotary position embedding block.
// No dependencies; every other file of the block imports this package.
package rope_pkg;

	localparam int CW = 34;

	typedef logic signed [31:0]   data_t;
	typedef logic signed [CW-1:0] cval_t;

	localparam logic [63:0] LOG2_TENK_Q32  = 64'd57070290109;
	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
	localparam cval_t       CORDIC_ONE_Q30 = 34'sd652032874;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// Item fields that ride along the rotation pipeline
	typedef struct packed {
		data_t qe;
		data_t qo;
		data_t ke;
		data_t ko;
		logic  rot_k;
	} rope_side_t;

	// Per-cell CORDIC state handed from one cell to the next
	typedef struct packed {
		cval_t      x;
		cval_t      y;
		cval_t      z;
		logic       flip;
		rope_side_t side;
	} rope_cell_t;

	// Integer square root, used only while building the frequency table
	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] op;
		logic [63:0] res;
		logic [63:0] bitv;
		op   = v;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > op)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (op >= res + bitv) begin
				op  = op - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/rope_cordic_cell.sv
// One rotation-mode CORDIC cell: a fixed shift and one arctangent step, registered.
// Depends on rope_pkg for the cell state type and the arctangent table.
module rope_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rope_pkg::rope_cell_t in_cell,
	output logic                 out_valid_s1,
	output rope_pkg::rope_cell_t out_cell_s1
);
	import rope_pkg::*;

	localparam cval_t ATAN = cval_t'({2'b00, ATAN_TURNS[STAGE]});

	rope_cell_t nxt;
	cval_t      dx;
	cval_t      dy;

	always_comb begin
		dx  = in_cell.y >>> STAGE;
		dy  = in_cell.x >>> STAGE;
		nxt = in_cell;
		if (!in_cell.z[CW-1]) begin
			nxt.x = in_cell.x - dx;
			nxt.y = in_cell.y + dy;
			nxt.z = in_cell.z - ATAN;
		end else begin
			nxt.x = in_cell.x + dx;
			nxt.y = in_cell.y - dy;
			nxt.z = in_cell.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_cell_s1 <= nxt;
	end

endmodule

FILE: hw/rtl/rope_rotator.sv
// Rotates one pair by cos/sin in Q30 with round-half-up and saturation, two stages.
// Depends on rope_pkg for data and cos/sin types.
module rope_rotator (
	input  logic            clk,
	input  rope_pkg::data_t even_in,
	input  rope_pkg::data_t odd_in,
	input  rope_pkg::cval_t cs,
	input  rope_pkg::cval_t sn,
	output rope_pkg::data_t even_s2,
	output rope_pkg::data_t odd_s2,
	output logic            sat_s2
);
	import rope_pkg::*;

	localparam int PW = 32 + CW;
	localparam int SW = PW + 2;

	localparam logic signed [SW-1:0] RND  = SW'(64'sd536870912);
	localparam logic signed [SW-1:0] VMAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] VMIN = SW'(-64'sd2147483648);

	logic signed [PW-1:0] p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	logic signed [SW-1:0] ev, od;
	logic                 ev_hi, ev_lo, od_hi, od_lo;

	always_ff @(posedge clk) begin
		p_ac_s1 <= PW'(even_in) * PW'(cs);
		p_bs_s1 <= PW'(odd_in) * PW'(sn);
		p_as_s1 <= PW'(even_in) * PW'(sn);
		p_bc_s1 <= PW'(odd_in) * PW'(cs);
	end

	always_comb begin
		ev    = (SW'(p_ac_s1) - SW'(p_bs_s1) + RND) >>> 30;
		od    = (SW'(p_as_s1) + SW'(p_bc_s1) + RND) >>> 30;
		ev_hi = ev > VMAX;
		ev_lo = ev < VMIN;
		od_hi = od > VMAX;
		od_lo = od < VMIN;
	end

	always_ff @(posedge clk) begin
		even_s2 <= ev_hi ? data_t'(32'h7FFFFFFF) : (ev_lo ? data_t'(32'h80000000) : ev[31:0]);
		odd_s2  <= od_hi ? data_t'(32'h7FFFFFFF) : (od_lo ? data_t'(32'h80000000) : od[31:0]);
		sat_s2  <= ev_hi | ev_lo | od_hi | od_lo;
	end

endmodule

FILE: hw/rtl/rotary_position_embedding.sv
// Rotary position embedding top level: index reduction, frequency table, phase, CORDIC chain
// and the two pair rotators. Depends on rope_pkg, rope_cordic_cell and rope_rotator.
//
// The block takes one item per clock cycle without pause: busy stays low, and a new item may
// be started in every cycle. Each item yields exactly one result. The path is CORDIC_STAGES + 6
// registers deep: 4 front stages for index reduction, table read and phase multiply, one
// register per CORDIC cell, and 2 rotator stages. Done is the valid bit of the last of these
// registers, and the result is taken at the edge that ends the cycle in which done is
// high. The receiver cannot stall, so it must take each result in the cycle done is high.
// The key width register is written through the cfg channel, which is always ready; write
// it only while no item is in flight.
module rotary_position_embedding #(
	parameter int HEAD_DIM      = 64,
	parameter int MAX_DIM       = 4096,
	parameter int CORDIC_STAGES = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [11:0]     position,
	input  logic [11:0]     element_index,
	input  rope_pkg::data_t query_even,
	input  rope_pkg::data_t query_odd,
	input  rope_pkg::data_t key_even,
	input  rope_pkg::data_t key_odd,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [12:0]     cfg_data,
	output logic            done,
	output rope_pkg::data_t query_even_out,
	output rope_pkg::data_t query_odd_out,
	output rope_pkg::data_t key_even_out,
	output rope_pkg::data_t key_odd_out,
	output logic            key_rotated,
	output logic            saturated
);
	import rope_pkg::*;

	localparam int JW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
	localparam logic [23:0] RECIP = 24'((1 << 24) / HEAD_DIM);
	localparam logic [12:0] HEAD_W = 13'(HEAD_DIM);
	localparam logic [13:0] MAX_DIM_W = 14'(MAX_DIM);

	typedef logic [47:0] freq_rom_t [HEAD_DIM];

	// Frequency of slot j in turns per position, Q48: 2^-(j*log2(10000)/H) / (2*pi)
	function automatic logic [47:0] freq_of(int unsigned j);
		logic [127:0] e;
		logic [127:0] c;
		logic [127:0] r;
		logic [31:0]  f;
		int unsigned  n;
		e = (128'(j) * 128'(LOG2_TENK_Q32)) / HEAD_DIM;
		n = 32'(e >> 32);
		f = e[31:0];
		c = 128'd1 << 31;
		r = 128'd1 << 32;
		for (int k = 1; k <= 32; k++) begin
			c = 128'(isqrt64(64'(c << 32)));
			if (f[32-k])
				r = (r * c) >> 32;
		end
		r = (r * 128'(INV_TWO_PI_Q32)) >> 16;
		return (n < 64) ? 48'(r >> n) : 48'd0;
	endfunction

	function automatic freq_rom_t build_rom();
		freq_rom_t rom;
		for (int j = 0; j < HEAD_DIM; j++)
			rom[j] = freq_of(j);
		return rom;
	endfunction

	localparam freq_rom_t FREQ_ROM = build_rom();

	// Configuration: always ready, width clamped to MAX_DIM at use
	logic [12:0] key_width_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_width_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			key_width_q <= cfg_data;
		end
	end

	// Stage 1: capture the item, estimate index / HEAD_DIM by reciprocal multiply
	logic [13:0] kw_clamp;
	logic        accept;
	logic [35:0] q_prod;
	rope_side_t  side_in;

	assign accept = start && !busy;

	always_comb begin
		kw_clamp      = ({1'b0, key_width_q} < MAX_DIM_W) ? {1'b0, key_width_q} : MAX_DIM_W;
		q_prod        = 36'(element_index) * 36'(RECIP);
		side_in.qe    = query_even;
		side_in.qo    = query_odd;
		side_in.ke    = key_even;
		side_in.ko    = key_odd;
		side_in.rot_k = {2'b00, element_index} < kw_clamp;
	end

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [11:0] pos_s1, pos_s2, pos_s3;
	logic [11:0] idx_s1, qt_s1;
	logic [JW-1:0] j_s2;
	logic [47:0] freq_s3;
	logic [31:0] angle_s4;
	rope_side_t  side_s1, side_s2, side_s3, side_s4;

	// Stage 2: remainder with one correction step (estimate is low by at most one)
	logic [12:0] rem_raw, rem_fix;

	always_comb begin
		rem_raw = 13'(idx_s1) - 13'(24'(qt_s1) * 24'(HEAD_DIM));
		rem_fix = (rem_raw >= HEAD_W) ? rem_raw - HEAD_W : rem_raw;
	end

	// Stage 4: phase = position * frequency mod one turn, keep top 32 bits of Q48
	logic [59:0] phase;

	assign phase = 60'(pos_s3) * 60'(freq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1   <= position;
		idx_s1   <= element_index;
		qt_s1    <= q_prod[35:24];
		side_s1  <= side_in;
		pos_s2   <= pos_s1;
		j_s2     <= rem_fix[JW-1:0];
		side_s2  <= side_s1;
		pos_s3   <= pos_s2;
		freq_s3  <= FREQ_ROM[j_s2];
		side_s3  <= side_s2;
		angle_s4 <= phase[47:16];
		side_s4  <= side_s3;
	end

	// Fold the angle into a quarter turn either side of zero; flip cos/sin at the end
	logic        fold;
	logic [31:0] zf;
	rope_cell_t  cell_in;

	always_comb begin
		fold = ($signed(angle_s4) > $signed(32'h40000000)) ||
		       ($signed(angle_s4) < $signed(32'hC0000000));
		zf   = fold ? angle_s4 + 32'h80000000 : angle_s4;
		cell_in.x    = CORDIC_ONE_Q30;
		cell_in.y    = '0;
		cell_in.z    = {{(CW-32){zf[31]}}, zf};
		cell_in.flip = fold;
		cell_in.side = side_s4;
	end

	// CORDIC chain: one cell per iteration, each passes its state on every cycle
	rope_cell_t chain [CORDIC_STAGES+1];
	logic       chain_v [CORDIC_STAGES+1];

	assign chain[0]   = cell_in;
	assign chain_v[0] = v_s4;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		rope_cordic_cell #(.STAGE(i)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.in_valid     (chain_v[i]),
			.in_cell      (chain[i]),
			.out_valid_s1 (chain_v[i+1]),
			.out_cell_s1  (chain[i+1])
		);
	end

	rope_cell_t last;
	cval_t      cs, sn;

	always_comb begin
		last = chain[CORDIC_STAGES];
		cs   = last.flip ? -last.x : last.x;
		sn   = last.flip ? -last.y : last.y;
	end

	// Rotators: two stages; hold the sideband alongside them
	data_t q_e, q_o, k_e, k_o;
	logic  q_sat, k_sat;

	rope_rotator u_rot_q (
		.clk     (clk),
		.even_in (last.side.qe),
		.odd_in  (last.side.qo),
		.cs      (cs),
		.sn      (sn),
		.even_s2 (q_e),
		.odd_s2  (q_o),
		.sat_s2  (q_sat)
	);

	rope_rotator u_rot_k (
		.clk     (clk),
		.even_in (last.side.ke),
		.odd_in  (last.side.ko),
		.cs      (cs),
		.sn      (sn),
		.even_s2 (k_e),
		.odd_s2  (k_o),
		.sat_s2  (k_sat)
	);

	logic       v_r1, v_r2;
	rope_side_t side_r1, side_r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
		end else begin
			v_r1 <= chain_v[CORDIC_STAGES];
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		side_r1 <= last.side;
		side_r2 <= side_r1;
	end

	// Pass the key pair through untouched when it is past the key width
	assign done           = v_r2;
	assign query_even_out = q_e;
	assign query_odd_out  = q_o;
	assign key_even_out   = side_r2.rot_k ? k_e : side_r2.ke;
	assign key_odd_out    = side_r2.rot_k ? k_o : side_r2.ko;
	assign key_rotated    = side_r2.rot_k;
	assign saturated      = q_sat | (side_r2.rot_k & k_sat);

endmodule
